/* rtl/core/bgs_pkg.sv */
// Shared constants and types for the bilinear grid sampler.
// No dependencies; used by every file in rtl/core.
package bgs_pkg;

	// default sizes of the grid and of a stored height
	localparam int GRID_SIDE_DEF   = 33;
	localparam int HEIGHT_BITS_DEF = 16;

	// fixed field widths
	localparam int COORD_W = 32;
	localparam int CELL_W  = 6;
	localparam int SIDE_W  = 6;
	localparam int SPC_W   = 11;
	localparam int LHGT_W  = 16;
	localparam int OUT_W   = 24;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 32;

	localparam int SPACING_MAX = 1024;

	// cell locator: one quotient bit per stage
	localparam int CELL_QB  = 6;
	localparam int CELL_RW  = 17;
	localparam int CELL_LAT = CELL_QB + 1;

	// final divide by spacing squared: one quotient bit per stage
	localparam int DIV_QB  = OUT_W - 1;
	localparam int DIV_DW  = 2 * SPC_W - 1;
	localparam int DIV_LAT = DIV_QB + 1;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_ORIGIN_X  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_ORIGIN_Z  = 2'd1;
	localparam logic [CFG_IW-1:0] REG_GRID_SIDE = 2'd2;
	localparam logic [CFG_IW-1:0] REG_SPACING   = 2'd3;

	// item kinds
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// load and kind details riding alongside the cell locators
	typedef struct packed {
		logic               act;
		logic [CELL_W-1:0]  col;
		logic [CELL_W-1:0]  row;
		logic [LHGT_W-1:0]  hgt;
	} side_t;

endpackage

/* rtl/core/bilinear_grid_sampler_top.sv */
// Bilinear grid sampler, top level: configuration, grid banks, interpolation.
// Depends on bgs_pkg, bgs_cell_div and bgs_div.
//
// Load words write one height into the grid; sample words return one
// floored 8-fraction-bit height each, loads return nothing. The block takes
// one word every cycle while no result waits at the output. The dividers
// work one bit per stage, with seven stages for the cell search and
// twenty-four for the divide by spacing squared. The grid is held in four
// banks split by row and column parity so the four corners are read in a
// single cycle; loads write at the same stage where samples read, so words
// act in arrival order. The whole pipeline holds while a result waits at
// the output. The grid needs no clearing after reset; configuration is
// taken at any time but must only change while no word is in flight.
module bilinear_grid_sampler_top #(
	parameter int GRID_SIDE   = bgs_pkg::GRID_SIDE_DEF,
	parameter int HEIGHT_BITS = bgs_pkg::HEIGHT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic [bgs_pkg::CELL_W-1:0]         grid_col,
	input  logic [bgs_pkg::CELL_W-1:0]         grid_row,
	input  logic signed [bgs_pkg::LHGT_W-1:0]  load_height,
	input  logic signed [bgs_pkg::COORD_W-1:0] world_x,
	input  logic signed [bgs_pkg::COORD_W-1:0] world_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [bgs_pkg::OUT_W-1:0]   sampled_height,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bgs_pkg::CFG_IW-1:0]         cfg_index,
	input  logic [bgs_pkg::CFG_DW-1:0]         cfg_data
);

	localparam int HBS = (GRID_SIDE + 1) / 2;
	localparam int BD  = HBS * HBS;
	localparam int ABW = (BD > 1) ? $clog2(BD) : 1;
	localparam int AW  = HEIGHT_BITS + 12;
	localparam int NW  = HEIGHT_BITS + 21;
	localparam int CL  = bgs_pkg::CELL_LAT;
	localparam int DL  = bgs_pkg::DIV_LAT;

	// configuration registers
	logic signed [bgs_pkg::COORD_W-1:0] origin_x_q, origin_z_q;
	logic [bgs_pkg::SIDE_W-1:0]         side_q;
	logic [bgs_pkg::SPC_W-1:0]          spacing_q;

	logic adv;

	// stage 1
	logic                               v_s1;
	bgs_pkg::side_t                     side_s1;
	logic signed [bgs_pkg::COORD_W:0]   dx_s1, dz_s1;

	// alongside the cell locators
	logic                               v_cs [CL];
	bgs_pkg::side_t                     side_cs [CL];
	logic [bgs_pkg::CELL_W-1:0]         cx, cz;
	logic [bgs_pkg::SPC_W-1:0]          fx, fz;

	// stage 2: bank addresses
	logic [ABW-1:0]                     addr_n [4];
	logic [3:0]                         we_n;
	logic [ABW-1:0]                     addr_s2 [4];
	logic [3:0]                         we_s2;
	logic signed [HEIGHT_BITS-1:0]      wd_s2;
	logic                               vs_s2, ip_s2, jp_s2;
	logic [bgs_pkg::SPC_W-1:0]          nx_s2, nz_s2;

	// stage 3: bank reads
	logic signed [HEIGHT_BITS-1:0]      rd_s3 [4];
	logic                               vs_s3, ip_s3, jp_s3;
	logic [bgs_pkg::SPC_W-1:0]          nx_s3, nz_s3;

	// stage 4 and 5: interpolation
	logic signed [AW-1:0]               a_s4, b_s4;
	logic                               vs_s4;
	logic [bgs_pkg::SPC_W-1:0]          nz_s4;
	logic signed [NW-1:0]               num_s5;
	logic [bgs_pkg::DIV_DW-1:0]         dsq_s5;
	logic                               vs_s5;

	// alongside the divider, then output
	logic                               vs_sd [DL];
	logic signed [bgs_pkg::OUT_W-1:0]   res;
	logic                               out_valid_q;
	logic signed [bgs_pkg::OUT_W-1:0]   out_hgt_q;

	logic [bgs_pkg::SPC_W-1:0]          wx0, wz0;
	logic signed [HEIGHT_BITS-1:0]      h00, h10, h01, h11;

	function automatic logic [ABW-1:0] baddr(logic [bgs_pkg::CELL_W-1:0] c,
		logic [bgs_pkg::CELL_W-1:0] r);
		return ABW'(int'(r[bgs_pkg::CELL_W-1:1]) * HBS + int'(c[bgs_pkg::CELL_W-1:1]));
	endfunction

	// pipeline moves unless a result waits
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	// configuration writes with saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_z_q <= '0;
			side_q     <= bgs_pkg::SIDE_W'(2);
			spacing_q  <= bgs_pkg::SPC_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				bgs_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data;
				bgs_pkg::REG_ORIGIN_Z: origin_z_q <= cfg_data;
				bgs_pkg::REG_GRID_SIDE: begin
					if (cfg_data[bgs_pkg::SIDE_W-1:0] < bgs_pkg::SIDE_W'(2))
						side_q <= bgs_pkg::SIDE_W'(2);
					else if ({1'b0, cfg_data[bgs_pkg::SIDE_W-1:0]} > 7'(GRID_SIDE))
						side_q <= bgs_pkg::SIDE_W'(GRID_SIDE);
					else
						side_q <= cfg_data[bgs_pkg::SIDE_W-1:0];
				end
				bgs_pkg::REG_SPACING: begin
					if (cfg_data[bgs_pkg::SPC_W-1:0] == '0)
						spacing_q <= bgs_pkg::SPC_W'(1);
					else if (cfg_data[bgs_pkg::SPC_W-1:0] > bgs_pkg::SPC_W'(bgs_pkg::SPACING_MAX))
						spacing_q <= bgs_pkg::SPC_W'(bgs_pkg::SPACING_MAX);
					else
						spacing_q <= cfg_data[bgs_pkg::SPC_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			for (int i = 0; i < CL; i++) v_cs[i] <= 1'b0;
			we_s2       <= '0;
			vs_s2       <= 1'b0;
			vs_s3       <= 1'b0;
			vs_s4       <= 1'b0;
			vs_s5       <= 1'b0;
			for (int i = 0; i < DL; i++) vs_sd[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_valid;
			v_cs[0] <= v_s1;
			for (int i = 1; i < CL; i++) v_cs[i] <= v_cs[i-1];
			we_s2   <= we_n;
			vs_s2   <= v_cs[CL-1] && side_cs[CL-1].act == bgs_pkg::ACT_SAMPLE;
			vs_s3   <= vs_s2;
			vs_s4   <= vs_s3;
			vs_s5   <= vs_s4;
			vs_sd[0] <= vs_s5;
			for (int i = 1; i < DL; i++) vs_sd[i] <= vs_sd[i-1];
			out_valid_q <= vs_sd[DL-1];
		end
	end

	// stage 1: capture word, offset from origin
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.act <= action;
			side_s1.col <= grid_col;
			side_s1.row <= grid_row;
			side_s1.hgt <= load_height;
			dx_s1 <= {world_x[bgs_pkg::COORD_W-1], world_x}
				- {origin_x_q[bgs_pkg::COORD_W-1], origin_x_q};
			dz_s1 <= {world_z[bgs_pkg::COORD_W-1], world_z}
				- {origin_z_q[bgs_pkg::COORD_W-1], origin_z_q};
			side_cs[0] <= side_s1;
			for (int i = 1; i < CL; i++) side_cs[i] <= side_cs[i-1];
		end
	end

	bgs_cell_div u_cell_x (
		.clk      (clk),
		.en       (adv),
		.delta    (dx_s1),
		.spacing  (spacing_q),
		.side     (side_q),
		.cell_idx (cx),
		.frac     (fx)
	);

	bgs_cell_div u_cell_z (
		.clk      (clk),
		.en       (adv),
		.delta    (dz_s1),
		.spacing  (spacing_q),
		.side     (side_q),
		.cell_idx (cz),
		.frac     (fz)
	);

	// bank b holds row parity b[1], column parity b[0]
	always_comb begin
		logic [bgs_pkg::CELL_W-1:0] cb, rb;
		logic                       in_rng;
		in_rng = ({1'b0, side_cs[CL-1].col} < 7'(GRID_SIDE)) &&
			({1'b0, side_cs[CL-1].row} < 7'(GRID_SIDE));
		for (int b = 0; b < 4; b++) begin
			if (side_cs[CL-1].act == bgs_pkg::ACT_LOAD) begin
				cb = side_cs[CL-1].col;
				rb = side_cs[CL-1].row;
				we_n[b] = v_cs[CL-1] && in_rng &&
					(rb[0] == b[1]) && (cb[0] == b[0]);
			end else begin
				cb = (cx[0] == b[0]) ? cx : cx + 1'b1;
				rb = (cz[0] == b[1]) ? cz : cz + 1'b1;
				we_n[b] = 1'b0;
			end
			addr_n[b] = baddr(cb, rb);
		end
	end

	// stage 2: stored height is sign-extended or truncated to the storage width
	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s2 <= addr_n;
			wd_s2   <= HEIGHT_BITS'($signed(side_cs[CL-1].hgt));
			ip_s2   <= cx[0];
			jp_s2   <= cz[0];
			nx_s2   <= fx;
			nz_s2   <= fz;
		end
	end

	// stage 3: grid banks, write and registered read
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic signed [HEIGHT_BITS-1:0] mem [BD];
		always_ff @(posedge clk) begin
			if (adv) begin
				if (we_s2[b]) mem[addr_s2[b]] <= wd_s2;
				rd_s3[b] <= mem[addr_s2[b]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ip_s3 <= ip_s2;
			jp_s3 <= jp_s2;
			nx_s3 <= nx_s2;
			nz_s3 <= nz_s2;
		end
	end

	// corners back from banks
	assign h00 = rd_s3[{jp_s3, ip_s3}];
	assign h10 = rd_s3[{jp_s3, !ip_s3}];
	assign h01 = rd_s3[{!jp_s3, ip_s3}];
	assign h11 = rd_s3[{!jp_s3, !ip_s3}];
	assign wx0 = spacing_q - nx_s3;
	assign wz0 = spacing_q - nz_s4;

	// stage 4: blend along x, stage 5: along z
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s4   <= h00 * $signed({1'b0, wx0}) + h10 * $signed({1'b0, nx_s3});
			b_s4   <= h01 * $signed({1'b0, wx0}) + h11 * $signed({1'b0, nx_s3});
			nz_s4  <= nz_s3;
			num_s5 <= a_s4 * $signed({1'b0, wz0}) + b_s4 * $signed({1'b0, nz_s4});
			dsq_s5 <= bgs_pkg::DIV_DW'(spacing_q) * bgs_pkg::DIV_DW'(spacing_q);
		end
	end

	bgs_div #(
		.NUM_W (NW)
	) u_div (
		.clk (clk),
		.en  (adv),
		.num (num_s5),
		.dsq (dsq_s5),
		.res (res)
	);

	// output register
	always_ff @(posedge clk) begin
		if (adv) out_hgt_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign sampled_height = out_hgt_q;

endmodule

/* rtl/core/bgs_cell_div.sv */
// Pipelined cell locator: floor-divides a coordinate offset by the spacing,
// clamps to the grid edge and yields cell index and fraction numerator.
// Depends on bgs_pkg.
module bgs_cell_div (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [bgs_pkg::COORD_W:0] delta,
	input  logic [bgs_pkg::SPC_W-1:0]        spacing,
	input  logic [bgs_pkg::SIDE_W-1:0]       side,
	output logic [bgs_pkg::CELL_W-1:0]       cell_idx,
	output logic [bgs_pkg::SPC_W-1:0]        frac
);

	typedef struct packed {
		logic                         neg;
		logic                         over;
		logic [bgs_pkg::CELL_RW-1:0]  rem;
		logic [bgs_pkg::CELL_QB-1:0]  q;
	} cst_t;

	cst_t st_s [bgs_pkg::CELL_QB+1];

	logic [bgs_pkg::CELL_RW-1:0] lim;

	// one restoring step for quotient bit k
	function automatic cst_t cstep(cst_t a, logic [bgs_pkg::SPC_W-1:0] s, int k);
		cst_t                        r;
		logic [bgs_pkg::CELL_RW-1:0] t;
		r = a;
		t = bgs_pkg::CELL_RW'(s) << k;
		if (a.rem >= t) begin
			r.rem  = a.rem - t;
			r.q[k] = 1'b1;
		end
		return r;
	endfunction

	// offset at which the cell passes the last one in use
	assign lim = bgs_pkg::CELL_RW'(side - 1'b1) * bgs_pkg::CELL_RW'(spacing);

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0].neg  <= delta[bgs_pkg::COORD_W];
			st_s[0].over <= !delta[bgs_pkg::COORD_W] &&
				(delta >= $signed({{(bgs_pkg::COORD_W + 1 - bgs_pkg::CELL_RW){1'b0}}, lim}));
			st_s[0].rem  <= delta[bgs_pkg::CELL_RW-1:0];
			st_s[0].q    <= '0;
			for (int i = 1; i <= bgs_pkg::CELL_QB; i++) begin
				st_s[i] <= cstep(st_s[i-1], spacing, bgs_pkg::CELL_QB - i);
			end
		end
	end

	// edge clamp
	always_comb begin
		if (st_s[bgs_pkg::CELL_QB].neg) begin
			cell_idx = '0;
			frac     = '0;
		end else if (st_s[bgs_pkg::CELL_QB].over) begin
			cell_idx = side - 2'd2;
			frac     = spacing;
		end else begin
			cell_idx = st_s[bgs_pkg::CELL_QB].q;
			frac     = st_s[bgs_pkg::CELL_QB].rem[bgs_pkg::SPC_W-1:0];
		end
	end

endmodule

/* rtl/core/bgs_div.sv */
// Pipelined floored division of the weighted sum (times 256) by the
// spacing squared, saturated to the result width. Depends on bgs_pkg.
module bgs_div #(
	parameter int NUM_W = bgs_pkg::HEIGHT_BITS_DEF + 21
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [NUM_W-1:0]          num,
	input  logic [bgs_pkg::DIV_DW-1:0]       dsq,
	output logic signed [bgs_pkg::OUT_W-1:0] res
);

	localparam int MW = NUM_W + 8;
	localparam int RW = bgs_pkg::DIV_DW + bgs_pkg::DIV_QB;
	localparam int CW = (MW > RW) ? MW : RW;

	typedef struct packed {
		logic                        neg;
		logic                        ovf;
		logic [bgs_pkg::DIV_DW-1:0]  d;
		logic [RW-1:0]               rem;
		logic [bgs_pkg::DIV_QB-1:0]  q;
	} dst_t;

	dst_t st_s [bgs_pkg::DIV_QB+1];

	logic [MW-1:0] nsh;
	logic [MW-1:0] mag;
	logic [RW-1:0] dtop;

	function automatic dst_t dstep(dst_t a, int k);
		dst_t          r;
		logic [RW-1:0] t;
		r = a;
		t = RW'(a.d) << k;
		if (a.rem >= t) begin
			r.rem  = a.rem - t;
			r.q[k] = 1'b1;
		end
		return r;
	endfunction

	// floor of a negative dividend: divide its complement, complement the quotient
	assign nsh  = {num, 8'h00};
	assign mag  = num[NUM_W-1] ? ~nsh : nsh;
	assign dtop = RW'(dsq) << bgs_pkg::DIV_QB;

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0].neg <= num[NUM_W-1];
			st_s[0].ovf <= CW'(mag) >= CW'(dtop);
			st_s[0].d   <= dsq;
			st_s[0].rem <= RW'(mag);
			st_s[0].q   <= '0;
			for (int i = 1; i <= bgs_pkg::DIV_QB; i++) begin
				st_s[i] <= dstep(st_s[i-1], bgs_pkg::DIV_QB - i);
			end
		end
	end

	// saturate and restore the sign
	always_comb begin
		if (st_s[bgs_pkg::DIV_QB].ovf) begin
			res = st_s[bgs_pkg::DIV_QB].neg ? {1'b1, {(bgs_pkg::OUT_W-1){1'b0}}}
				: {1'b0, {(bgs_pkg::OUT_W-1){1'b1}}};
		end else if (st_s[bgs_pkg::DIV_QB].neg) begin
			res = ~{1'b0, st_s[bgs_pkg::DIV_QB].q};
		end else begin
			res = {1'b0, st_s[bgs_pkg::DIV_QB].q};
		end
	end

endmodule
